/* rtl/background_color_estimator_defines.svh */
// Assertion macros for the background color estimator.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef BACKGROUND_COLOR_ESTIMATOR_DEFINES_SVH
`define BACKGROUND_COLOR_ESTIMATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define BCE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define BCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define BCE_ASSERT_SAME(lbl, ante, cons, msg)
`define BCE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/bce_pkg.sv */
package bce_pkg;

  // Field and register widths
  localparam int PIX_W   = 8;
  localparam int FW_W    = 13;
  localparam int STEP_W  = 7;
  localparam int THR_W   = 10;
  localparam int PHASE_W = 6;
  localparam int DIFF_W  = 10;
  localparam int TOT_W   = 11;

  // APB port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [1:0] REG_SAMPLE_STEP = 2'd1;
  localparam logic [1:0] REG_THRESHOLD   = 2'd2;

  // Register reset values
  localparam logic [FW_W-1:0]   FRAME_WIDTH_RST = 13'd640;
  localparam logic [STEP_W-1:0] SAMPLE_STEP_RST = 7'd4;
  localparam logic [THR_W-1:0]  THRESHOLD_RST   = 10'd60;

  // Algorithm constants
  localparam logic [PIX_W-1:0] REF_RESET    = 8'd160;
  localparam int               ACCEPT_LIMIT = 64;
  localparam int               STEP_LIMIT   = 64;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int COUNT_BITS_DEF = 21;

  // Divider: one quotient bit per cycle
  localparam int DIV_STEPS = PIX_W;
  localparam int K_W       = $clog2(DIV_STEPS);

  // Channel select codes
  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  typedef struct packed {
    logic [FW_W-1:0]   frame_width;
    logic [STEP_W-1:0] sample_step;
    logic [THR_W-1:0]  match_threshold;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       accept;   // pixel transfer: capture, seed, advance position
    logic       div_load; // load divider with sum of load_ch
    logic [1:0] load_ch;
    logic       div_step; // one quotient bit
    logic       div_last; // final bit: write mean of chan
    logic [1:0] chan;
    logic       merge;    // compare pixel to means, maybe accumulate
    logic       publish;  // result to output register, update reference
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sampled; // current pixel lies on the sampling grid
  } stat_t;

endpackage

/* rtl/bce_regs.sv */
module bce_regs
  import bce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  logic [FW_W-1:0]   frame_width_r;
  logic [STEP_W-1:0] sample_step_r;
  logic [THR_W-1:0]  threshold_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= FRAME_WIDTH_RST;
      sample_step_r <= SAMPLE_STEP_RST;
      threshold_r   <= THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH: frame_width_r <= cfg_pwdata[FW_W-1:0];
        REG_SAMPLE_STEP: sample_step_r <= cfg_pwdata[STEP_W-1:0];
        REG_THRESHOLD:   threshold_r   <= cfg_pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH: cfg_prdata = {{(DATA_W-FW_W){1'b0}}, frame_width_r};
      REG_SAMPLE_STEP: cfg_prdata = {{(DATA_W-STEP_W){1'b0}}, sample_step_r};
      REG_THRESHOLD:   cfg_prdata = {{(DATA_W-THR_W){1'b0}}, threshold_r};
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg.frame_width     = frame_width_r;
  assign cfg.sample_step     = sample_step_r;
  assign cfg.match_threshold = threshold_r;

endmodule

/* rtl/bce_ctrl.sv */
module bce_ctrl
  import bce_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  input  logic  in_tlast,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DLOAD,
    ST_DSTEP,
    ST_MERGE,
    ST_RESULT
  } state_t;

  state_t         state_r, state_nxt;
  logic [1:0]     ch_r, ch_nxt;
  logic [K_W-1:0] k_r, k_nxt;
  logic           final_r, final_nxt;  // divider pass feeds the result
  logic           last_r, last_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           k_end;

  assign k_end      = (k_r == K_W'(DIV_STEPS - 1));
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    k_nxt         = k_r;
    final_nxt     = final_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cmd           = '0;
    cmd.chan      = ch_r;
    cmd.load_ch   = CH_BLUE;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          last_nxt   = in_tlast;
          final_nxt  = ~stat.sampled;
          if (stat.sampled || in_tlast) begin
            state_nxt = ST_DLOAD;
          end
        end
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        cmd.load_ch  = CH_BLUE;
        ch_nxt       = CH_BLUE;
        k_nxt        = '0;
        state_nxt    = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.div_step = 1'b1;
        cmd.div_last = k_end;
        k_nxt        = k_r + K_W'(1);
        if (k_end) begin
          if (ch_r != CH_RED) begin
            // chain straight into the next channel
            cmd.div_load = 1'b1;
            cmd.load_ch  = ch_r + 2'd1;
            ch_nxt       = ch_r + 2'd1;
          end else if (final_r) begin
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_MERGE;
          end
        end
      end
      ST_MERGE: begin
        cmd.merge = 1'b1;
        if (last_r) begin
          final_nxt = 1'b1;
          state_nxt = ST_DLOAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESULT: begin
        // wait until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= CH_BLUE;
      k_r         <= '0;
      final_r     <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      k_r         <= k_nxt;
      final_r     <= final_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/bce_datapath.sv */
module bce_datapath
  import bce_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [PIX_W-1:0] in_blue,
  input  logic [PIX_W-1:0] in_green,
  input  logic [PIX_W-1:0] in_red,
  output logic [PIX_W-1:0] out_mean_blue,
  output logic [PIX_W-1:0] out_mean_green,
  output logic [PIX_W-1:0] out_mean_red,
  output logic             out_accepted
);

  localparam int SUM_W = COUNT_BITS + PIX_W;
  localparam int POS_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = (POS_W + 1 > FW_W) ? POS_W + 1 : FW_W;
  localparam logic signed [TOT_W-1:0] LIM = TOT_W'(ACCEPT_LIMIT);

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Frame state
  logic [SUM_W-1:0]      sum_b_r, sum_g_r, sum_r_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [POS_W-1:0]      pos_r;
  logic [PHASE_W-1:0]    col_ph_r, row_ph_r;
  logic                  started_r;
  logic [PIX_W-1:0]      ref_b_r, ref_g_r, ref_r_r;

  // Captured pixel and means
  logic [PIX_W-1:0] pix_b_r, pix_g_r, pix_r_r;
  logic [PIX_W-1:0] mean_b_r, mean_g_r, mean_r_r;

  // Divider
  logic [SUM_W-1:0] rem_r, dvs_r, load_sum;
  logic [PIX_W-1:0] quo_r, quo_nxt;
  logic             div_ge;

  // Output register
  logic [PIX_W-1:0] res_b_r, res_g_r, res_r_r;
  logic             res_acc_r;

  // Position and phase advance
  logic [CMP_W-1:0]  width_eff, fw_ext, pos_inc;
  logic [STEP_W-1:0] step_eff, col_ph_inc, row_ph_inc;
  logic              row_wrap;

  assign fw_ext = CMP_W'(cfg.frame_width);
  always_comb begin
    if (fw_ext == '0) begin
      width_eff = CMP_W'(1);
    end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = fw_ext;
    end
    if (cfg.sample_step == '0) begin
      step_eff = STEP_W'(1);
    end else if (cfg.sample_step > STEP_W'(STEP_LIMIT)) begin
      step_eff = STEP_W'(STEP_LIMIT);
    end else begin
      step_eff = cfg.sample_step;
    end
  end

  assign pos_inc    = {{(CMP_W-POS_W){1'b0}}, pos_r} + CMP_W'(1);
  assign row_wrap   = (pos_inc >= width_eff);
  assign col_ph_inc = {1'b0, col_ph_r} + STEP_W'(1);
  assign row_ph_inc = {1'b0, row_ph_r} + STEP_W'(1);

  assign stat.sampled = (col_ph_r == '0) && (row_ph_r == '0);

  // Divider operand select and one restoring step
  always_comb begin
    case (cmd.load_ch)
      CH_BLUE:  load_sum = sum_b_r;
      CH_GREEN: load_sum = sum_g_r;
      default:  load_sum = sum_r_r;
    endcase
  end

  assign div_ge  = (rem_r >= dvs_r);
  assign quo_nxt = {quo_r[PIX_W-2:0], div_ge};

  // Sample match test
  logic [DIFF_W-1:0] sad;
  logic              hit;

  assign sad = DIFF_W'(abs_diff(pix_b_r, mean_b_r))
             + DIFF_W'(abs_diff(pix_g_r, mean_g_r))
             + DIFF_W'(abs_diff(pix_r_r, mean_r_r));
  assign hit = (sad < cfg.match_threshold) && (count_r != '1);

  // Distance of the means from the reference color
  logic signed [TOT_W-1:0] total;
  logic                    ok;

  assign total = $signed({{(TOT_W-PIX_W){1'b0}}, mean_b_r})
               - $signed({{(TOT_W-PIX_W){1'b0}}, ref_b_r})
               + $signed({{(TOT_W-PIX_W){1'b0}}, mean_g_r})
               - $signed({{(TOT_W-PIX_W){1'b0}}, ref_g_r})
               + $signed({{(TOT_W-PIX_W){1'b0}}, mean_r_r})
               - $signed({{(TOT_W-PIX_W){1'b0}}, ref_r_r});
  assign ok = (total < LIM) && (total > -LIM);

  // Frame state and reference color
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_b_r   <= '0;
      sum_g_r   <= '0;
      sum_r_r   <= '0;
      count_r   <= '0;
      pos_r     <= '0;
      col_ph_r  <= '0;
      row_ph_r  <= '0;
      started_r <= 1'b0;
      ref_b_r   <= REF_RESET;
      ref_g_r   <= REF_RESET;
      ref_r_r   <= REF_RESET;
    end else begin
      if (cmd.accept) begin
        // first pixel seeds the sums
        if (!started_r) begin
          sum_b_r   <= {{(SUM_W-PIX_W){1'b0}}, in_blue};
          sum_g_r   <= {{(SUM_W-PIX_W){1'b0}}, in_green};
          sum_r_r   <= {{(SUM_W-PIX_W){1'b0}}, in_red};
          count_r   <= COUNT_BITS'(1);
          started_r <= 1'b1;
        end
        if (row_wrap) begin
          pos_r    <= '0;
          col_ph_r <= '0;
          row_ph_r <= (row_ph_inc >= step_eff) ? '0 : row_ph_inc[PHASE_W-1:0];
        end else begin
          pos_r    <= pos_r + POS_W'(1);
          col_ph_r <= (col_ph_inc >= step_eff) ? '0 : col_ph_inc[PHASE_W-1:0];
        end
      end
      if (cmd.merge && hit) begin
        sum_b_r <= sum_b_r + {{(SUM_W-PIX_W){1'b0}}, pix_b_r};
        sum_g_r <= sum_g_r + {{(SUM_W-PIX_W){1'b0}}, pix_g_r};
        sum_r_r <= sum_r_r + {{(SUM_W-PIX_W){1'b0}}, pix_r_r};
        count_r <= count_r + COUNT_BITS'(1);
      end
      if (cmd.publish) begin
        if (ok) begin
          ref_b_r <= mean_b_r;
          ref_g_r <= mean_g_r;
          ref_r_r <= mean_r_r;
        end
        sum_b_r   <= '0;
        sum_g_r   <= '0;
        sum_r_r   <= '0;
        count_r   <= '0;
        pos_r     <= '0;
        col_ph_r  <= '0;
        row_ph_r  <= '0;
        started_r <= 1'b0;
      end
    end
  end

  // Pixel capture, divider, means and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_b_r <= in_blue;
      pix_g_r <= in_green;
      pix_r_r <= in_red;
    end
    if (cmd.div_load) begin
      rem_r <= load_sum;
      dvs_r <= {1'b0, count_r, {(PIX_W-1){1'b0}}};
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? rem_r - dvs_r : rem_r;
      dvs_r <= dvs_r >> 1;
      quo_r <= quo_nxt;
    end
    if (cmd.div_step && cmd.div_last) begin
      case (cmd.chan)
        CH_BLUE:  mean_b_r <= quo_nxt;
        CH_GREEN: mean_g_r <= quo_nxt;
        default:  mean_r_r <= quo_nxt;
      endcase
    end
    if (cmd.publish) begin
      res_b_r   <= mean_b_r;
      res_g_r   <= mean_g_r;
      res_r_r   <= mean_r_r;
      res_acc_r <= ok;
    end
  end

  assign out_mean_blue  = res_b_r;
  assign out_mean_green = res_g_r;
  assign out_mean_red   = res_r_r;
  assign out_accepted   = res_acc_r;

endmodule

/* rtl/background_color_estimator.sv */
// Pixel off the sampling grid and not last: next pixel taken right after.
// Sampled pixel: shared one-bit-per-cycle divider forms 3 means x 8 bits, then a merge.
// Last pixel: means recomputed (after the merge if sampled), then the result is registered.
// Output register lets the next frame start while a result waits on out_tready.
// Reset (rst_n, synchronous, active low): sums, count and positions clear,
// reference color 160/160/160, registers 640/4/60; no clearing pass.
`include "background_color_estimator_defines.svh"

module background_color_estimator
  import bce_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input pixel stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [3*PIX_W-1:0]  in_tdata,   // blue, green, red
  input  logic                in_tlast,   // frame_end
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [3*PIX_W-1:0]  out_tdata,  // mean_blue, mean_green, mean_red
  output logic                out_tuser,  // accepted
  // configuration
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [ADDR_W-1:0]   cfg_paddr,
  input  logic [DATA_W-1:0]   cfg_pwdata,
  output logic [DATA_W-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  cfg_t             cfg;
  cmd_t             cmd;
  stat_t            stat;
  logic [PIX_W-1:0] mean_b, mean_g, mean_r;

  bce_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bce_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .in_blue        (in_tdata[PIX_W-1:0]),
    .in_green       (in_tdata[2*PIX_W-1:PIX_W]),
    .in_red         (in_tdata[3*PIX_W-1:2*PIX_W]),
    .out_mean_blue  (mean_b),
    .out_mean_green (mean_g),
    .out_mean_red   (mean_r),
    .out_accepted   (out_tuser)
  );

  assign out_tdata = {mean_r, mean_g, mean_b};

  // Checks
  `BCE_ASSERT_NEXT(a_no_result_mid_frame, in_tvalid && in_tready && !in_tlast && !out_tvalid, !out_tvalid, "result appeared after a pixel that is not the last")
  `BCE_ASSERT_NEXT(a_publish_shows, cmd.publish, out_tvalid, "published result not presented")
  `BCE_ASSERT_SAME(a_idle_no_divide, in_tready, !cmd.div_step && !cmd.merge, "divider busy while accepting pixels")
  `BCE_ASSERT_SAME(a_cmd_exclusive, 1'b1, $onehot0({cmd.accept, cmd.div_step, cmd.merge, cmd.publish}), "conflicting datapath commands")

endmodule

/* test/background_color_estimator_test.sv */
`timescale 1ns / 100ps

module background_color_estimator_test
  import bce_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_TARGET = 500;
  localparam int SETTLE      = 80;   // covers a sampled pixel plus the end-of-frame means
  localparam int LONG_HOLD   = 600;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS_DEF) - 1;

  typedef struct {
    logic [PIX_W-1:0] mean_blue;
    logic [PIX_W-1:0] mean_green;
    logic [PIX_W-1:0] mean_red;
    logic             accepted;
  } estimate_t;

  // Tracks the running background estimate and the results it must produce
  class background_estimate_board;
    logic [FW_W-1:0]   frame_width;
    logic [STEP_W-1:0] sample_step;
    logic [THR_W-1:0]  match_threshold;
    longint unsigned   sum_blue, sum_green, sum_red, hit_count;
    int unsigned       col_pos, col_phase, row_phase;
    bit                frame_open;
    logic [PIX_W-1:0]  ref_blue, ref_green, ref_red;
    estimate_t         expected_estimates[$];
    int unsigned       errors;

    function new();
      frame_width     = FRAME_WIDTH_RST;
      sample_step     = SAMPLE_STEP_RST;
      match_threshold = THRESHOLD_RST;
      ref_blue        = REF_RESET;
      ref_green       = REF_RESET;
      ref_red         = REF_RESET;
      errors          = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      sum_blue   = 0;
      sum_green  = 0;
      sum_red    = 0;
      hit_count  = 0;
      col_pos    = 0;
      col_phase  = 0;
      row_phase  = 0;
      frame_open = 0;
    endfunction

    function int channel_gap(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_FRAME_WIDTH: frame_width = value[FW_W-1:0];
        REG_SAMPLE_STEP: sample_step = value[STEP_W-1:0];
        REG_THRESHOLD:   match_threshold = value[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return expected_estimates.size();
    endfunction

    // One accepted pixel transfer
    function void note_pixel(logic [3*PIX_W-1:0] data, logic frame_end);
      int unsigned b, g, r, width, step;
      int          diff, total;
      estimate_t   est;
      b = data[PIX_W-1:0];
      g = data[2*PIX_W-1:PIX_W];
      r = data[3*PIX_W-1:2*PIX_W];
      width = (frame_width == 0) ? 1 :
              (frame_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : frame_width;
      step  = (sample_step == 0) ? 1 :
              (sample_step > STEP_LIMIT) ? STEP_LIMIT : sample_step;

      // first pixel seeds the sums
      if (!frame_open) begin
        sum_blue   = b;
        sum_green  = g;
        sum_red    = r;
        hit_count  = 1;
        frame_open = 1;
      end

      // grid sample: join the mean when close enough
      if (col_phase == 0 && row_phase == 0) begin
        diff = channel_gap(b, int'(sum_blue / hit_count))
             + channel_gap(g, int'(sum_green / hit_count))
             + channel_gap(r, int'(sum_red / hit_count));
        if (diff < int'(match_threshold) && hit_count < COUNT_MAX) begin
          sum_blue  += b;
          sum_green += g;
          sum_red   += r;
          hit_count++;
        end
      end

      // raster position
      if (col_pos + 1 >= width) begin
        col_pos   = 0;
        col_phase = 0;
        row_phase = (row_phase + 1 >= step) ? 0 : row_phase + 1;
      end else begin
        col_pos++;
        col_phase = (col_phase + 1 >= step) ? 0 : col_phase + 1;
      end

      if (!frame_end) return;

      est.mean_blue  = PIX_W'(sum_blue / hit_count);
      est.mean_green = PIX_W'(sum_green / hit_count);
      est.mean_red   = PIX_W'(sum_red / hit_count);
      total = (int'(est.mean_blue) - int'(ref_blue))
            + (int'(est.mean_green) - int'(ref_green))
            + (int'(est.mean_red) - int'(ref_red));
      est.accepted = (((total < 0) ? -total : total) < ACCEPT_LIMIT);
      if (est.accepted) begin
        ref_blue  = est.mean_blue;
        ref_green = est.mean_green;
        ref_red   = est.mean_red;
      end
      expected_estimates = {expected_estimates, est};
      clear_frame();
    endfunction

    // One accepted result transfer
    function void check_estimate(logic [3*PIX_W-1:0] data, logic accepted);
      estimate_t est;
      if (expected_estimates.size() == 0) begin
        $error("result with no estimate pending: tdata %h tuser %b", data, accepted);
        errors++;
        return;
      end
      est = expected_estimates.pop_front();
      if (data[PIX_W-1:0] !== est.mean_blue) begin
        $error("mean_blue: expected %0d, actual %0d", est.mean_blue, data[PIX_W-1:0]);
        errors++;
      end
      if (data[2*PIX_W-1:PIX_W] !== est.mean_green) begin
        $error("mean_green: expected %0d, actual %0d", est.mean_green,
               data[2*PIX_W-1:PIX_W]);
        errors++;
      end
      if (data[3*PIX_W-1:2*PIX_W] !== est.mean_red) begin
        $error("mean_red: expected %0d, actual %0d", est.mean_red,
               data[3*PIX_W-1:2*PIX_W]);
        errors++;
      end
      if (accepted !== est.accepted) begin
        $error("accepted: expected %0d, actual %0d", est.accepted, accepted);
        errors++;
      end
    endfunction
  endclass

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [3*PIX_W-1:0]  in_tdata    = '0;  // blue, green, red
  logic                in_tlast    = 1'b0; // frame_end
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [3*PIX_W-1:0]  out_tdata;          // mean_blue, mean_green, mean_red
  logic                out_tuser;          // accepted
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0]   cfg_paddr   = '0;
  logic [DATA_W-1:0]   cfg_pwdata  = '0;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  background_estimate_board board = new();

  bit          idling_on   = 1'b1;
  bit          hold_off_req = 1'b0;
  int unsigned pixels_sent = 0;
  int unsigned cycle_count = 0;

  background_color_estimator u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Transfer monitor: results first, then the pixel taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_estimate(out_tdata, out_tuser);
      if (in_tvalid && in_tready) board.note_pixel(in_tdata, in_tlast);
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [PIX_W-1:0] jitter(logic [PIX_W-1:0] base, int spread);
    int v;
    v = int'(base) + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  // Result receiver
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_tready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
        if (stall == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
          out_tready <= 1'b1;
        end
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] r, input logic frame_end);
    int gap;
    gap = idling_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, g, b};
    in_tlast  <= frame_end;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  task automatic end_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
  endtask

  // Quiet point: every result in, then let an unfinished pixel settle
  task automatic wait_idle();
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.write_reg(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Idle the block, then program all three registers; junk in the upper bits
  task automatic apply_settings(input int width, input int step, input int thr);
    logic [DATA_W-1:0] value;
    end_input();
    wait_idle();
    value = $urandom;
    value[FW_W-1:0] = FW_W'(width);
    write_reg(REG_FRAME_WIDTH, value);
    value = $urandom;
    value[STEP_W-1:0] = STEP_W'(step);
    write_reg(REG_SAMPLE_STEP, value);
    value = $urandom;
    value[THR_W-1:0] = THR_W'(thr);
    write_reg(REG_THRESHOLD, value);
  endtask

  // A frame of pixels around one base color, with some outliers
  task automatic send_frame(input int len, input bit with_end);
    logic [PIX_W-1:0] base_b, base_g, base_r;
    int spread;
    if ($urandom_range(0, 9) < 6) begin
      base_b = jitter(board.ref_blue, 12);
      base_g = jitter(board.ref_green, 12);
      base_r = jitter(board.ref_red, 12);
    end else begin
      base_b = PIX_W'($urandom);
      base_g = PIX_W'($urandom);
      base_r = PIX_W'($urandom);
    end
    spread = $urandom_range(0, 15);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) != 0)
        send_pixel(jitter(base_b, spread), jitter(base_g, spread), jitter(base_r, spread),
                   with_end && (i == len - 1));
      else
        send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                   with_end && (i == len - 1));
    end
  endtask

  function automatic int pick_width();
    case ($urandom_range(0, 9))
      7:       return $urandom_range(17, 700);
      8:       return $urandom_range(0, 8191);
      9:       return ($urandom_range(0, 2) == 0) ? 0 :
                      ($urandom_range(0, 1) == 0) ? MAX_WIDTH_DEF : 8191;
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  function automatic int pick_step();
    case ($urandom_range(0, 9))
      7:       return $urandom_range(7, 64);
      8:       return $urandom_range(0, 127);
      9:       return ($urandom_range(0, 1) == 0) ? 0 : 127;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int pick_threshold();
    case ($urandom_range(0, 9))
      6, 7:    return $urandom_range(0, 765);
      8:       return $urandom_range(766, 1023);
      9:       return ($urandom_range(0, 1) == 0) ? 0 : 765;
      default: return $urandom_range(20, 250);
    endcase
  endfunction

  initial begin
    int phase;
    int frames;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: extreme single-pixel frames, then a frame near the reference
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd160, 8'd160, 8'd160, 1'b0);
    send_pixel(8'd165, 8'd158, 8'd162, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd128, 1'b0);
    send_pixel(8'd150, 8'd170, 8'd160, 1'b1);

    // Zero width and step, threshold above the largest difference
    apply_settings(0, 0, 1023);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd128, 8'd127, 8'd1, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);

    // Oversized width and step, zero threshold
    apply_settings(8191, 127, 0);
    send_pixel(8'd10, 8'd20, 8'd30, 1'b0);
    send_pixel(8'd200, 8'd100, 8'd50, 1'b1);

    // Settings changed in the middle of a frame
    apply_settings(3, 2, 200);
    for (int i = 0; i < 5; i++) send_pixel(PIX_W'(100 + i), 8'd90, PIX_W'(80 - i), 1'b0);
    apply_settings(MAX_WIDTH_DEF, STEP_LIMIT, 765);
    send_pixel(8'd101, 8'd91, 8'd79, 1'b0);
    send_pixel(8'd99, 8'd92, 8'd81, 1'b0);
    send_pixel(8'd103, 8'd88, 8'd77, 1'b1);

    // Random phases; frames may run on across a settings change
    phase = 0;
    while (pixels_sent < ITEM_TARGET) begin
      apply_settings(pick_width(), pick_step(), pick_threshold());
      if (phase == 2 || phase == 9) begin
        // receiver holds off while short frames keep coming
        idling_on    = 1'b0;
        hold_off_req = 1'b1;
        for (int i = 0; i < 4; i++) send_frame(2, 1'b1);
      end else begin
        idling_on = ($urandom_range(0, 3) != 0);
        frames = $urandom_range(1, 4);
        for (int i = 0; i < frames; i++)
          send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(31, 120)
                                                  : $urandom_range(1, 30),
                     (i < frames - 1) || ($urandom_range(0, 4) != 0));
      end
      phase++;
    end

    end_input();
    wait_idle();
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* background_color_estimator.f */
+incdir+rtl
rtl/bce_pkg.sv
rtl/bce_regs.sv
rtl/bce_ctrl.sv
rtl/bce_datapath.sv
rtl/background_color_estimator.sv
test/background_color_estimator_test.sv
